FILE: sv/xmcs_pkg.sv
// ---------------------------------------------------------------------------
// XMODEM checksum engine package
// Shared constants, codes and control structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xmcs_pkg;

  localparam int PAYLOAD_BYTES = 128;
  localparam int FRAME_BYTES   = 132;
  localparam int MEM_DEPTH     = 2 * PAYLOAD_BYTES;
  localparam int MEM_AW        = $clog2(MEM_DEPTH);
  localparam int OFF_W         = $clog2(PAYLOAD_BYTES);

  localparam logic [7:0] PAYLOAD_LEN = 8'(PAYLOAD_BYTES);
  localparam logic [7:0] FRAME_LAST  = 8'(FRAME_BYTES - 1);
  localparam logic [7:0] HDR_BYTES   = 8'd3;

  // link characters
  localparam logic [7:0] CH_SOH = 8'd1;
  localparam logic [7:0] CH_EOT = 8'd4;
  localparam logic [7:0] CH_ACK = 8'd6;
  localparam logic [7:0] CH_NAK = 8'd21;
  localparam logic [7:0] CH_CAN = 8'd24;

  typedef enum logic [2:0] {
    CMD_START_SEND = 3'd0,
    CMD_START_RECV = 3'd1,
    CMD_ABORT      = 3'd2,
    CMD_LINK_READ  = 3'd3,
    CMD_LINK_WRITE = 3'd4,
    CMD_STAGE_BYTE = 3'd5,
    CMD_STAGE_END  = 3'd6,
    CMD_HOST_READ  = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_SENT     = 4'd1,
    EV_RESENT   = 4'd2,
    EV_EOT_SENT = 4'd3,
    EV_RX_GOOD  = 4'd4,
    EV_RX_BAD   = 4'd5,
    EV_EOT_RX   = 4'd6,
    EV_ACK      = 4'd7,
    EV_NAK      = 4'd8,
    EV_CANCEL   = 4'd9
  } ev_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2
  } mode_e;

  // reply we owe (receiver) or last thing sent (sender)
  typedef enum logic [1:0] {
    RP_NONE = 2'd0,
    RP_ACK  = 2'd1,
    RP_NAK  = 2'd2,
    RP_EOT  = 2'd3
  } reply_e;

  // last reply seen from the peer
  typedef enum logic [1:0] {
    PR_NONE  = 2'd0,
    PR_ACK   = 2'd1,
    PR_NAK   = 2'd2,
    PR_OTHER = 2'd3
  } peer_e;

  // where the RAM read data lands in the result
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_LINK = 2'd1,
    SEL_HOST = 2'd2
  } byte_sel_e;

  typedef struct packed {
    logic        link_valid;
    logic [7:0]  link_byte;
    ev_e         event_res;
    mode_e       mode;
    logic [7:0]  block_number;
    logic [7:0]  host_byte;
    logic [7:0]  staged_count;
    logic        block_committed;
    byte_sel_e   sel;
  } res_t;

  typedef struct packed {
    logic              re;
    logic [MEM_AW-1:0] raddr;
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [7:0]        wdata;
  } ram_req_t;

endpackage

`default_nettype wire

FILE: sv/xmcs_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xmcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/xmcs_ctrl.sv
// ---------------------------------------------------------------------------
// XMODEM protocol control
// Sender/receiver state, frame bookkeeping and payload RAM addressing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xmcs_ctrl
  import xmcs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [2:0] cmd_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [6:0] payload_index_i,
  output ram_req_t        ram_req_o,
  output res_t            res_o
);

  mode_e      mode_q, mode_d;
  reply_e     pend_q, pend_d;
  peer_e      peer_q, peer_d;
  logic [7:0] fidx_q, fidx_d;
  logic [7:0] nblk_q, nblk_d;
  logic       bank_q, bank_d;
  logic [7:0] fblk_q, fblk_d;
  logic [7:0] fcmp_q, fcmp_d;
  logic [7:0] fsum_q, fsum_d;
  logic [7:0] flen_q, flen_d;
  logic [7:0] flead_q, flead_d;
  logic [7:0] scnt_q, scnt_d;
  logic [7:0] ssum_q, ssum_d;
  logic       send_q, send_d;

  logic [7:0] off;
  logic       good;
  cmd_e       cmd;

  assign off  = fidx_q - HDR_BYTES;
  assign cmd  = cmd_e'(cmd_i);
  assign good = (flead_q == CH_SOH) && (fblk_q == ~fcmp_q) && (fsum_q == data_byte_i);

  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    peer_d  = peer_q;
    fidx_d  = fidx_q;
    nblk_d  = nblk_q;
    bank_d  = bank_q;
    fblk_d  = fblk_q;
    fcmp_d  = fcmp_q;
    fsum_d  = fsum_q;
    flen_d  = flen_q;
    flead_d = flead_q;
    scnt_d  = scnt_q;
    ssum_d  = ssum_q;
    send_d  = send_q;

    ram_req_o = '0;
    res_o     = '0;

    case (cmd)
      CMD_START_SEND, CMD_START_RECV: begin
        mode_d = (cmd == CMD_START_SEND) ? MODE_SEND : MODE_RECV;
        fidx_d = '0;
        pend_d = RP_NAK;
        peer_d = PR_NONE;
        nblk_d = 8'd1;
        if (cmd == CMD_START_RECV) begin
          flen_d = '0;
          scnt_d = '0;
          ssum_d = '0;
          send_d = 1'b0;
        end
      end
      CMD_ABORT: begin
        if (mode_q != MODE_IDLE) res_o.event_res = EV_CANCEL;
        mode_d = MODE_IDLE;
        fidx_d = '0;
        pend_d = RP_NONE;
        peer_d = PR_NONE;
      end
      CMD_LINK_READ: begin
        if (mode_q == MODE_SEND) begin
          if (fidx_q != '0) begin
            res_o.link_valid = 1'b1;
            if (fidx_q == 8'd1) begin
              res_o.link_byte = fblk_q;
            end else if (fidx_q == 8'd2) begin
              res_o.link_byte = fcmp_q;
            end else if (fidx_q == FRAME_LAST) begin
              res_o.link_byte = fsum_q;
            end else if (off < flen_q) begin
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = {bank_q, off[OFF_W-1:0]};
              res_o.sel       = SEL_LINK;
            end
            if (fidx_q == FRAME_LAST) begin
              fidx_d = '0;
              peer_d = PR_NONE;
              pend_d = RP_ACK;
            end else begin
              fidx_d = fidx_q + 8'd1;
            end
          end else if ((pend_q == RP_NAK && peer_q == PR_NAK) ||
                       (pend_q == RP_ACK && peer_q == PR_ACK)) begin
            if (scnt_q >= PAYLOAD_LEN || (scnt_q != '0 && send_q)) begin
              bank_d  = ~bank_q;
              flen_d  = scnt_q;
              fsum_d  = ssum_q;
              flead_d = CH_SOH;
              fblk_d  = nblk_q;
              fcmp_d  = ~nblk_q;
              nblk_d  = nblk_q + 8'd1;
              scnt_d  = '0;
              ssum_d  = '0;
              peer_d  = PR_NONE;
              pend_d  = RP_ACK;
              fidx_d  = 8'd1;
              res_o.link_valid = 1'b1;
              res_o.link_byte  = CH_SOH;
              res_o.event_res  = EV_SENT;
            end else if (scnt_q == '0 && send_q) begin
              peer_d = PR_NONE;
              pend_d = RP_EOT;
              res_o.link_valid = 1'b1;
              res_o.link_byte  = CH_EOT;
              res_o.event_res  = EV_EOT_SENT;
            end
          end else if (peer_q == PR_NAK) begin
            peer_d = PR_NONE;
            res_o.link_valid = 1'b1;
            if (pend_q == RP_EOT) begin
              res_o.link_byte = CH_EOT;
              res_o.event_res = EV_EOT_SENT;
            end else begin
              fidx_d = 8'd1;
              res_o.link_byte = flead_q;
              res_o.event_res = EV_RESENT;
            end
          end
        end else if (mode_q == MODE_RECV) begin
          if (pend_q == RP_EOT) begin
            pend_d = RP_NONE;
            mode_d = MODE_IDLE;
            res_o.link_valid = 1'b1;
            res_o.link_byte  = CH_ACK;
            res_o.event_res  = EV_ACK;
          end else if (pend_q == RP_ACK || pend_q == RP_NAK) begin
            pend_d = RP_NONE;
            res_o.link_valid = 1'b1;
            res_o.link_byte  = (pend_q == RP_ACK) ? CH_ACK : CH_NAK;
            res_o.event_res  = (pend_q == RP_ACK) ? EV_ACK : EV_NAK;
          end
        end
      end
      CMD_LINK_WRITE: begin
        if (mode_q == MODE_SEND) begin
          if (data_byte_i == CH_ACK) begin
            peer_d = PR_ACK;
            res_o.event_res = EV_ACK;
            if (pend_q == RP_EOT) mode_d = MODE_IDLE;
          end else if (data_byte_i == CH_NAK) begin
            peer_d = PR_NAK;
            res_o.event_res = EV_NAK;
          end else if (data_byte_i == CH_CAN) begin
            peer_d = PR_OTHER;
            res_o.event_res = EV_CANCEL;
            mode_d = MODE_IDLE;
          end else begin
            peer_d = PR_OTHER;
          end
        end else if (mode_q == MODE_RECV) begin
          if (fidx_q == '0) begin
            if (data_byte_i == CH_EOT) begin
              pend_d = RP_EOT;
              res_o.event_res = EV_EOT_RX;
            end else begin
              flead_d = data_byte_i;
              fsum_d  = '0;
              fidx_d  = 8'd1;
            end
          end else if (fidx_q == 8'd1) begin
            fblk_d = data_byte_i;
            fidx_d = 8'd2;
          end else if (fidx_q == 8'd2) begin
            fcmp_d = data_byte_i;
            fidx_d = 8'd3;
          end else if (fidx_q < FRAME_LAST) begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = {bank_q, off[OFF_W-1:0]};
            ram_req_o.wdata = data_byte_i;
            fsum_d = fsum_q + data_byte_i;
            fidx_d = fidx_q + 8'd1;
          end else begin
            // trailing checksum byte closes the frame
            fidx_d = '0;
            pend_d = good ? RP_ACK : RP_NAK;
            res_o.event_res = good ? EV_RX_GOOD : EV_RX_BAD;
            if (good && fblk_q == nblk_q) begin
              nblk_d = nblk_q + 8'd1;
              bank_d = ~bank_q;
              res_o.block_committed = 1'b1;
            end
          end
        end
      end
      CMD_STAGE_BYTE: begin
        if (mode_q != MODE_RECV && scnt_q < PAYLOAD_LEN) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = {~bank_q, scnt_q[OFF_W-1:0]};
          ram_req_o.wdata = data_byte_i;
          scnt_d = scnt_q + 8'd1;
          ssum_d = ssum_q + data_byte_i;
        end
      end
      CMD_STAGE_END: begin
        if (mode_q != MODE_RECV) send_d = 1'b1;
      end
      CMD_HOST_READ: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = {~bank_q, payload_index_i};
        res_o.sel       = SEL_HOST;
      end
      default: begin
      end
    endcase

    // state after the word
    res_o.mode         = mode_d;
    res_o.block_number = nblk_d;
    res_o.staged_count = scnt_d;

    // nothing reaches RAM unless the word is taken
    ram_req_o.re = ram_req_o.re & accept_i;
    ram_req_o.we = ram_req_o.we & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pend_q  <= RP_NONE;
      peer_q  <= PR_NONE;
      fidx_q  <= '0;
      nblk_q  <= 8'd1;
      bank_q  <= 1'b0;
      fblk_q  <= '0;
      fcmp_q  <= '0;
      fsum_q  <= '0;
      flen_q  <= '0;
      flead_q <= '0;
      scnt_q  <= '0;
      ssum_q  <= '0;
      send_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      peer_q  <= peer_d;
      fidx_q  <= fidx_d;
      nblk_q  <= nblk_d;
      bank_q  <= bank_d;
      fblk_q  <= fblk_d;
      fcmp_q  <= fcmp_d;
      fsum_q  <= fsum_d;
      flen_q  <= flen_d;
      flead_q <= flead_d;
      scnt_q  <= scnt_d;
      ssum_q  <= ssum_d;
      send_q  <= send_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/xmcs_out.sv
// ---------------------------------------------------------------------------
// Result pipeline
// Holds a word while its RAM read completes, merges the read byte and
// keeps an output register toward the master side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xmcs_out
  import xmcs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire res_t        res_i,
  input  wire logic [7:0]  rdata_i,
  output logic             ready_o,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic [39:0]      m_data_o
);

  logic  pv_q;
  res_t  pres_q;
  logic  ov_q;
  res_t  ores_q, ores_d;
  logic  p_adv;

  // RAM data stays put until the next accept, which needs the stage moved on
  assign p_adv   = pv_q && (!ov_q || m_ready_i);
  assign ready_o = !pv_q || p_adv;

  always_comb begin
    ores_d = pres_q;
    case (pres_q.sel)
      SEL_LINK: ores_d.link_byte = rdata_i;
      SEL_HOST: ores_d.host_byte = rdata_i;
      default:  ores_d.sel       = SEL_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (accept_i) begin
        pv_q <= 1'b1;
      end else if (p_adv) begin
        pv_q <= 1'b0;
      end
      if (p_adv) begin
        ov_q <= 1'b1;
      end else if (m_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pres_q <= res_i;
    end
    if (p_adv) begin
      ores_q <= ores_d;
    end
  end

  assign m_valid_o = ov_q;
  assign m_data_o  = {ores_q.block_committed, ores_q.staged_count, ores_q.host_byte,
                      ores_q.block_number, ores_q.mode, ores_q.event_res,
                      ores_q.link_byte, ores_q.link_valid};

endmodule

`default_nettype wire

FILE: sv/xmodem_checksum_transfer_engine.sv
// An accepted word is registered in the hold stage with its RAM read, then in
// the output register, from which the master takes it.
// One word per cycle if the master keeps up; at most one RAM access per word
// (read or write), and its registered read sets the two-stage result path.
// Reset clears protocol state and the result pipeline at once; the payload
// RAM is not cleared, entries read before being written return junk.
// ---------------------------------------------------------------------------
// XMODEM checksum transfer engine
// 128-byte checksum XMODEM sender/receiver behind a byte link port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xmodem_checksum_transfer_engine
  import xmcs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // data_byte[7:0], payload_index[14:8]
  input  wire logic [2:0]  s_axis_tuser,  // cmd[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // link_valid[0], link_byte[8:1],
                                          // event_res[12:9], mode[14:13],
                                          // block_number[22:15], host_byte[30:23],
                                          // staged_count[38:31], block_committed[39]
);

  logic       accept;
  ram_req_t   ram_req;
  res_t       res;
  logic [7:0] rdata;

  assign accept = s_axis_tvalid && s_axis_tready;

  xmcs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .cmd_i           (s_axis_tuser),
    .data_byte_i     (s_axis_tdata[7:0]),
    .payload_index_i (s_axis_tdata[14:8]),
    .ram_req_o       (ram_req),
    .res_o           (res)
  );

  xmcs_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  xmcs_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .res_i     (res),
    .rdata_i   (rdata),
    .ready_o   (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
